// ===== rtl/grid_min_path_sum_macros.svh =====
// assertion macros shared by the grid_min_path_sum checker
`ifndef GRID_MIN_PATH_SUM_MACROS_SVH
`define GRID_MIN_PATH_SUM_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define GMPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define GMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gmps_pkg.sv =====
// shared types and constants for the grid minimum path sum block
package gmps_pkg;

    localparam int COST_W = 16;
    localparam int SUM_W  = 32;
    localparam int CFG_W  = 7;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // word index of the num_cols register (paddr[2])
    localparam logic REG_NUM_COLS = 1'b0;

    // per-transaction control broadcast to every cell of the row buffer
    typedef struct packed {
        logic             advance;
        logic             wrap;
        logic [SUM_W-1:0] best;
    } cell_ctrl_t;

endpackage

// ===== rtl/gmps_cell.sv =====
// one column cell of the row buffer: holds a best sum and the column token
module gmps_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gmps_pkg::cell_ctrl_t        ctrl,
    input  logic                        tok_in,
    output logic                        tok,
    output logic [gmps_pkg::SUM_W-1:0]  rd_next
);

    logic                       tok_reg;
    logic                       tok_next;
    logic [gmps_pkg::SUM_W-1:0] entry_reg;
    logic [gmps_pkg::SUM_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.advance && tok_reg)
        begin
            entry_next = ctrl.best;
        end

        // token moves to the neighbor on each transaction, back to the head on row end or on the last cell
        tok_next = tok_reg;
        if (ctrl.wrap)
        begin
            tok_next = IS_HEAD;
        end
        else if (ctrl.advance)
        begin
            tok_next = tok_in;
        end

        // value above the next cell, already including this cycle's write
        rd_next = tok_next ? entry_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= IS_HEAD;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok = tok_reg;

endmodule

// ===== rtl/grid_min_path_sum.sv =====
// top level: streamed right/down minimum path sum over a grid
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tdata = cell_cost, tlast = last_cell
//  m_*       out        m_tvalid/m_tready  tdata = path_sum, tuser = overflow
//  apb       in         psel/penable       num_cols at byte address 0
//
// one cell per clock cycle while s_tready is high; each transaction does one add and compare and
// one write into the row of column cells, and the value above the next
// column is gathered from the cells into a register for the following cycle.
// reset clears counters, flags and the column token; the row entries need no clearing.
// s_tready drops only while a result is held and m_tready is low.
module grid_min_path_sum #(
    parameter int MAX_COLS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gmps_pkg::COST_W-1:0]   s_tdata,   // [15:0] cell_cost
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gmps_pkg::SUM_W-1:0]    m_tdata,   // [31:0] path_sum
    output logic [0:0]                    m_tuser,   // [0] overflow
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmps_pkg::APB_AW-1:0]   paddr,
    input  logic [gmps_pkg::APB_DW-1:0]   pwdata,
    output logic [gmps_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int SW = gmps_pkg::SUM_W;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = (CW + 1 > gmps_pkg::CFG_W) ? CW + 1 : gmps_pkg::CFG_W;

    logic [gmps_pkg::CFG_W-1:0] num_cols_reg;
    logic [CW-1:0]              col_reg;
    logic [CW-1:0]              col_next;
    logic                       first_row_reg;
    logic                       first_row_next;
    logic [SW-1:0]              left_reg;
    logic [SW-1:0]              left_next;
    logic                       sat_reg;
    logic                       sat_next;
    logic [SW-1:0]              above_reg;
    logic [SW-1:0]              above_next;
    logic                       out_valid_reg;
    logic [SW-1:0]              out_sum_reg;
    logic                       out_ovf_reg;

    logic                       accept;
    logic                       cfg_write;
    logic [AW-1:0]              act_cols;
    logic [AW-1:0]              col_p1;
    logic                       row_end;
    logic [SW-1:0]              base;
    logic [SW:0]                sum_wide;
    logic                       ovf;
    logic [SW-1:0]              best;
    gmps_pkg::cell_ctrl_t       ctrl;
    logic [MAX_COLS-1:0]        tok;
    logic [SW-1:0]              rd_next [MAX_COLS];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == gmps_pkg::REG_NUM_COLS);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == gmps_pkg::REG_NUM_COLS)
        begin
            prdata = gmps_pkg::APB_DW'(num_cols_reg);
        end
    end

    // stream handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        // effective width: zero acts as one, clamp at the row length
        if (num_cols_reg == '0)
        begin
            act_cols = AW'(1);
        end
        else if (AW'(num_cols_reg) > AW'(MAX_COLS))
        begin
            act_cols = AW'(MAX_COLS);
        end
        else
        begin
            act_cols = AW'(num_cols_reg);
        end

        col_p1  = AW'(col_reg) + AW'(1);
        row_end = (col_p1 >= act_cols);

        priority if (first_row_reg)
        begin
            base = (col_reg == '0) ? '0 : left_reg;
        end
        else if (col_reg == '0)
        begin
            base = above_reg;
        end
        else
        begin
            base = (above_reg < left_reg) ? above_reg : left_reg;
        end

        sum_wide = (SW + 1)'(base) + (SW + 1)'(s_tdata);
        ovf      = sum_wide[SW];
        best     = ovf ? gmps_pkg::SUM_MAX : sum_wide[SW-1:0];

        ctrl.advance = accept;
        ctrl.wrap    = accept && (row_end || s_tlast);
        ctrl.best    = best;

        col_next       = col_reg;
        first_row_next = first_row_reg;
        left_next      = left_reg;
        sat_next       = sat_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                col_next       = '0;
                first_row_next = 1'b1;
                left_next      = '0;
                sat_next       = 1'b0;
            end
            else
            begin
                col_next  = row_end ? '0 : col_p1[CW-1:0];
                left_next = best;
                sat_next  = sat_reg || ovf;
                if (row_end)
                begin
                    first_row_next = 1'b0;
                end
            end
        end
    end

    // row of column cells
    for (genvar i = 0; i < MAX_COLS; i++)
    begin : g_cell
        gmps_cell #(
            .IS_HEAD (i == 0)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .tok_in  ((i == 0) ? 1'b0 : tok[(i == 0) ? 0 : i - 1]),
            .tok     (tok[i]),
            .rd_next (rd_next[i])
        );
    end

    // only the cell holding the token drives a nonzero value
    always_comb
    begin
        above_next = '0;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            above_next = above_next | rd_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg  <= gmps_pkg::CFG_W'(1);
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            left_reg      <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                num_cols_reg <= pwdata[gmps_pkg::CFG_W-1:0];
            end
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
            left_reg      <= left_next;
            sat_reg       <= sat_next;
            if (accept && s_tlast)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        above_reg <= above_next;
        if (accept && s_tlast)
        begin
            out_sum_reg <= best;
            out_ovf_reg <= sat_reg || ovf;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_sum_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule

// ===== rtl/gmps_checker.sv =====
// port-level checks for grid_min_path_sum and the bind that attaches them
`include "grid_min_path_sum_macros.svh"

module gmps_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        pready
);

    // a held result keeps its value until taken
    `GMPS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a result appears only after the final cell of a grid
    `GMPS_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast), "result without a final cell transaction")

    // every final cell transaction yields a result in the next cycle
    `GMPS_ASSERT_NEXT(a_out_follow, clk, rst_n, s_tvalid && s_tready && s_tlast, m_tvalid, "final cell transaction gave no result")

    // input is taken whenever the output slot can drain
    `GMPS_ASSERT_NOW(a_in_ready, clk, rst_n, !m_tvalid || m_tready, s_tready && pready, "input stalled with a free output slot")

endmodule

bind grid_min_path_sum gmps_checker u_gmps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the streamed grid minimum path sum block
module testbench;

    localparam int GRID_COLS   = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYC  = 8;
    localparam int PHASE_CELLS = 325;

    // tracks the row buffer dp and holds the path sums still owed by the block
    class path_scoreboard;
        typedef struct {
            logic [gmps_pkg::SUM_W-1:0] path_sum;
            logic                       overflow;
        } path_result_t;

        bit [gmps_pkg::SUM_W-1:0] row_best[GRID_COLS];
        bit                       ever_written[GRID_COLS];
        bit [gmps_pkg::SUM_W-1:0] left_best;
        int unsigned              column_index;
        bit                       first_row;
        bit                       sat_seen;
        bit [gmps_pkg::CFG_W-1:0] num_cols;
        path_result_t             pending[$];
        int                       errors;

        function new();
            foreach (row_best[i])
            begin
                row_best[i]     = '0;
                ever_written[i] = 1'b0;
            end
            left_best    = '0;
            column_index = 0;
            first_row    = 1'b1;
            sat_seen     = 1'b0;
            num_cols     = gmps_pkg::CFG_W'(1);
            errors       = 0;
        endfunction

        function void set_width(bit [gmps_pkg::CFG_W-1:0] value);
            num_cols = value;
        endfunction

        function int unsigned active_width(bit [gmps_pkg::CFG_W-1:0] value);
            if (value == 0)
                return 1;
            if (value > GRID_COLS)
                return GRID_COLS;
            return 32'(value);
        endfunction

        // number of leading columns written at least once since reset
        function int unsigned written_span();
            int unsigned n;
            n = 0;
            while (n < GRID_COLS && ever_written[n])
                n++;
            return n;
        endfunction

        function void note_cell(bit [gmps_pkg::COST_W-1:0] cost, bit is_last);
            bit [gmps_pkg::SUM_W-1:0] base;
            bit [gmps_pkg::SUM_W:0]   total;
            bit [gmps_pkg::SUM_W-1:0] best;
            path_result_t             res;
            if (first_row)
                base = (column_index == 0) ? '0 : left_best;
            else if (column_index == 0)
                base = row_best[0];
            else
                base = (row_best[column_index] < left_best) ? row_best[column_index]
                                                            : left_best;
            total = {1'b0, base}
                    + {{(gmps_pkg::SUM_W-gmps_pkg::COST_W+1){1'b0}}, cost};
            if (total[gmps_pkg::SUM_W])
            begin
                best     = gmps_pkg::SUM_MAX;
                sat_seen = 1'b1;
            end
            else
                best = total[gmps_pkg::SUM_W-1:0];
            row_best[column_index]     = best;
            ever_written[column_index] = 1'b1;
            left_best                  = best;
            if (column_index + 1 >= active_width(num_cols))
            begin
                column_index = 0;
                first_row    = 1'b0;
            end
            else
                column_index++;
            if (is_last)
            begin
                res.path_sum = best;
                res.overflow = sat_seen;
                pending.push_back(res);
                left_best    = '0;
                column_index = 0;
                first_row    = 1'b1;
                sat_seen     = 1'b0;
            end
        endfunction

        function void check_result(logic [gmps_pkg::SUM_W-1:0] path_sum, logic overflow);
            path_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result path_sum %h overflow %b",
                         $time, path_sum, overflow);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (path_sum !== want.path_sum)
            begin
                $display("%0t: path_sum mismatch, expected %h actual %h",
                         $time, want.path_sum, path_sum);
                errors++;
            end
            if (overflow !== want.overflow)
            begin
                $display("%0t: overflow mismatch, expected %b actual %b",
                         $time, want.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [gmps_pkg::COST_W-1:0]   s_tdata = '0;     // [15:0] cell_cost
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [gmps_pkg::SUM_W-1:0]    m_tdata;          // [31:0] path_sum
    logic [0:0]                    m_tuser;          // [0] overflow
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [gmps_pkg::APB_AW-1:0]   paddr = '0;
    logic [gmps_pkg::APB_DW-1:0]   pwdata = '0;
    logic [gmps_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    path_scoreboard sb = new();
    int send_idle_pct = 0;
    int ready_stall_pct = 0;
    int cycle_count = 0;
    int cells_sent = 0;

    grid_min_path_sum #(.MAX_COLS(GRID_COLS)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= ready_stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);

    function automatic bit [gmps_pkg::COST_W-1:0] pick_cost();
        unique case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return gmps_pkg::COST_W'($urandom_range(15));
            default: return gmps_pkg::COST_W'($urandom);
        endcase
    endfunction

    function automatic bit [gmps_pkg::CFG_W-1:0] pick_width();
        unique case ($urandom_range(19))
            0: return '0;
            1: return gmps_pkg::CFG_W'($urandom_range(65, 127));
            2: return gmps_pkg::CFG_W'(GRID_COLS);
            3, 4: return gmps_pkg::CFG_W'($urandom_range(9, 63));
            default: return gmps_pkg::CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // present one cell and hold it until the block takes it
    task automatic send_cell(input bit [gmps_pkg::COST_W-1:0] cost, input bit is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cost;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_cell(cost, is_last);
        cells_sent++;
    endtask

    // let the block drain before touching the register
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // write num_cols, then read it back
    task automatic write_num_cols(input bit [gmps_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {gmps_pkg::REG_NUM_COLS, 2'b00};
        pwdata  <= {{(gmps_pkg::APB_DW-gmps_pkg::CFG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_width(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {{(gmps_pkg::APB_DW-gmps_pkg::CFG_W){1'b0}}, value})
        begin
            $display("%0t: num_cols readback mismatch, expected %h actual %h",
                     $time, value, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one random grid, sometimes cut short or resized partway through
    task automatic random_grid();
        int unsigned w;
        int unsigned cells;
        int unsigned cut;
        bit [gmps_pkg::CFG_W-1:0] new_width;
        w = sb.active_width(sb.num_cols);
        cells = w * ((w > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5));
        if ($urandom_range(4) == 0)
            cells = $urandom_range(1, cells);
        cut = ($urandom_range(9) == 0 && cells > 1) ? $urandom_range(1, cells - 1) : 0;
        for (int unsigned i = 0; i < cells; i++)
        begin
            if (cut != 0 && i == cut)
            begin
                settle();
                new_width = pick_width();
                // below the first row only columns that were written may be read
                if (!sb.first_row && sb.active_width(new_width) > sb.written_span())
                    new_width = gmps_pkg::CFG_W'(sb.written_span());
                write_num_cols(new_width);
            end
            send_cell(pick_cost(), i == cells - 1);
        end
    endtask

    initial
    begin
        int phase_send[4];
        int phase_stall[4];
        phase_send  = '{0, 59, 0, 25};
        phase_stall = '{0, 0, 59, 25};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width: one column, three rows, extremes of the cost
        send_cell('1, 1'b0);
        send_cell('0, 1'b0);
        send_cell(16'h0001, 1'b1);
        // single cell grid
        send_cell(16'h8000, 1'b1);
        settle();
        // zero width behaves as one column
        write_num_cols(7'd0);
        send_cell(16'h5555, 1'b0);
        send_cell(16'haaaa, 1'b1);
        settle();
        // 2x3 grid where the cheap route bends
        write_num_cols(7'd3);
        send_cell(16'd1, 1'b0);
        send_cell(16'd9, 1'b0);
        send_cell(16'd1, 1'b0);
        send_cell(16'd1, 1'b0);
        send_cell(16'd1, 1'b0);
        send_cell(16'd7, 1'b1);
        settle();
        // grid ending inside a row
        write_num_cols(7'd2);
        send_cell(16'd4, 1'b0);
        send_cell(16'd2, 1'b0);
        send_cell(16'd3, 1'b1);
        settle();
        // oversized width clamps to the row buffer depth
        write_num_cols(7'd127);
        send_cell(16'h1234, 1'b0);
        send_cell(16'h4321, 1'b1);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct   = phase_send[p];
            ready_stall_pct = phase_stall[p];
            cells_sent = 0;
            while (cells_sent < PHASE_CELLS)
            begin
                if ($urandom_range(3) == 0)
                begin
                    settle();
                    write_num_cols(pick_width());
                end
                random_grid();
            end
            settle();
        end

        s_tvalid <= 1'b0;
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== grid_min_path_sum.f =====
+incdir+rtl
rtl/gmps_pkg.sv
rtl/gmps_cell.sv
rtl/grid_min_path_sum.sv
rtl/gmps_checker.sv
tb/testbench.sv
